### sv/mdh_pkg.sv
// Shared types and constants for the metal detect drop hysteresis block.
package mdh_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned DROP_W     = 13;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned CONF_W     = 7;
    localparam int unsigned PROD_W     = SAMPLE_W + CONF_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CONF_W-1:0]   CONF_SCALE = 7'd100;
    localparam logic [CONF_W-1:0]   CONF_MAX   = 7'd100;
    localparam int unsigned         CONF_RAMP  = 3;
    localparam int unsigned         MIN_HELD   = 2;

    // floor(x / 3) as (x * 171) >> 9, exact for x below 256
    localparam logic [7:0]          RAMP_RECIP = 8'd171;
    localparam int unsigned         RAMP_SHIFT = 9;

    localparam logic [SAMPLE_W-1:0] BASE_RESET = 12'd0;
    localparam logic [SAMPLE_W-1:0] THR_RESET  = 12'd100;
    localparam logic [HOLD_W-1:0]   HOLD_RESET = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASELINE  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_HOLD      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### sv/metal_detect_drop_hysteresis.sv
// Top level of the moving-average drop detector with hold time.
//
// Each accepted transaction writes the sample into the history ring, sums the
// n held samples one entry per cycle, and runs the average and, when the drop
// magnitude exceeds a nonzero threshold, the confidence division on one shared
// bit-serial divider of 19 steps. The ramp scaling for fewer than three held
// samples is a reciprocal multiply. in_stall is high after an accepted
// transaction until its result is loaded into the output register, also while
// the finished result waits on a stalled output. The result sits in an output
// register, so the next sample may be taken while the previous result is still
// stalled. Configuration writes are taken in any cycle and must only be issued
// while the block is idle.
module metal_detect_drop_hysteresis
    import mdh_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [SAMPLE_W-1:0]         sample,
    input  logic [TIME_W-1:0]           time_ms,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        detected,
    output logic signed [DROP_W-1:0]    reported_drop,
    output logic [SAMPLE_W-1:0]         average,
    output logic [CONF_W-1:0]           confidence,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned POS_W   = $clog2(HISTORY_DEPTH);
    localparam int unsigned CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SUM_W   = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int unsigned DIV_N_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int unsigned DIV_D_W = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
    localparam int unsigned RAMP_W  = CONF_W + 2 + $bits(RAMP_RECIP);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_WRITE     = 9'b000000010,
        S_SUM       = 9'b000000100,
        S_DIV_AVG   = 9'b000001000,
        S_DECIDE    = 9'b000010000,
        S_CONF      = 9'b000100000,
        S_DIV_CONF  = 9'b001000000,
        S_SCALE     = 9'b010000000,
        S_FINISH    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] base_reg, thr_reg;
    logic [HOLD_W-1:0]   hold_reg;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                active_reg, active_next;
    logic [TIME_W-1:0]   start_reg, start_next;

    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic signed [DROP_W-1:0] rep_reg, rep_next;
    logic [SAMPLE_W-1:0] mag_reg, mag_next;
    logic [CONF_W-1:0]   conf_reg, conf_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     det_out_reg;
    logic signed [DROP_W-1:0] drop_out_reg;
    logic [SAMPLE_W-1:0]      avg_out_reg;
    logic [CONF_W-1:0]        conf_out_reg;
    logic                     out_load;

    logic                ring_wr_en, ring_rd_en;
    logic [SAMPLE_W-1:0] ring_rd_data;

    logic                div_start;
    logic [DIV_N_W-1:0]  div_dividend;
    logic [DIV_D_W-1:0]  div_divisor;
    logic [DIV_N_W-1:0]  div_quo;
    div_stat_t           div_stat;

    logic signed [DROP_W-1:0] raw_drop, filt_drop, rep_drop, thr_s;
    logic                     want;
    logic [TIME_W-1:0]        elapsed;
    logic [SAMPLE_W-1:0]      conf_diff;
    logic [PROD_W-1:0]        conf_prod;
    logic [CONF_W+1:0]        ramp_prod;
    logic [RAMP_W-1:0]        ramp_scaled;
    logic                     accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            thr_reg  <= THR_RESET;
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASELINE:  base_reg <= cfg_data[SAMPLE_W-1:0];
                REG_THRESHOLD: thr_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_HOLD:      hold_reg <= cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    mdh_ring #(
        .DEPTH (HISTORY_DEPTH),
        .POS_W (POS_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (rd_idx_reg[POS_W-1:0]),
        .rd_data (ring_rd_data)
    );

    mdh_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign raw_drop  = $signed({1'b0, base_reg}) - $signed({1'b0, sample_reg});
    assign filt_drop = $signed({1'b0, base_reg}) - $signed({1'b0, avg_reg});
    assign thr_s     = $signed({1'b0, thr_reg});
    assign want      = (raw_drop >= thr_s) && (cnt_reg >= CNT_W'(MIN_HELD));
    assign elapsed   = time_reg - start_reg;
    assign conf_diff = mag_reg - thr_reg;
    assign conf_prod = PROD_W'(conf_diff) * PROD_W'(CONF_SCALE);
    assign ramp_prod = (CONF_W + 2)'(conf_reg) * (CONF_W + 2)'(cnt_reg[1:0]);
    assign ramp_scaled = RAMP_W'(ramp_prod) * RAMP_W'(RAMP_RECIP);

    always_comb
    begin
        if (want && !active_reg)
        begin
            active_next = 1'b1;
            start_next  = time_reg;
        end
        else if (!want && active_reg && (elapsed > TIME_W'(hold_reg)))
        begin
            active_next = 1'b0;
            start_next  = start_reg;
        end
        else
        begin
            active_next = active_reg;
            start_next  = start_reg;
        end
        rep_drop = (!active_next && (filt_drop > raw_drop)) ? filt_drop : raw_drop;
    end

    always_comb
    begin
        case (state_reg)
            S_SUM:
            begin
                div_dividend = DIV_N_W'(acc_reg);
                div_divisor  = DIV_D_W'(cnt_reg);
            end
            default:
            begin
                div_dividend = DIV_N_W'(conf_prod);
                div_divisor  = DIV_D_W'(thr_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        sample_next = sample_reg;
        time_next   = time_reg;
        rd_idx_next = rd_idx_reg;
        rd_vld_next = 1'b0;
        acc_next    = acc_reg;
        avg_next    = avg_reg;
        rep_next    = rep_reg;
        mag_next    = mag_reg;
        conf_next   = conf_reg;
        ring_wr_en  = 1'b0;
        ring_rd_en  = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample;
                    time_next   = time_ms;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ring_wr_en  = 1'b1;
                pos_next    = (pos_reg == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                if (cnt_reg < CNT_W'(HISTORY_DEPTH))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                rd_idx_next = '0;
                acc_next    = '0;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                if (rd_idx_reg < cnt_reg)
                begin
                    ring_rd_en  = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    acc_next = acc_reg + SUM_W'(ring_rd_data);
                end
                if ((rd_idx_reg == cnt_reg) && !rd_vld_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_AVG;
                end
            end
            S_DIV_AVG:
            begin
                if (div_stat.done)
                begin
                    avg_next   = div_quo[SAMPLE_W-1:0];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                rep_next   = rep_drop;
                mag_next   = rep_drop[DROP_W-1] ? SAMPLE_W'(-rep_drop)
                                                : SAMPLE_W'(rep_drop);
                state_next = S_CONF;
            end
            S_CONF:
            begin
                if (thr_reg == '0)
                begin
                    conf_next  = (mag_reg != '0) ? CONF_MAX : '0;
                    state_next = S_SCALE;
                end
                else if (mag_reg <= thr_reg)
                begin
                    conf_next  = '0;
                    state_next = S_SCALE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_CONF;
                end
            end
            S_DIV_CONF:
            begin
                if (div_stat.done)
                begin
                    conf_next  = (div_quo > DIV_N_W'(CONF_MAX)) ? CONF_MAX
                                                                : div_quo[CONF_W-1:0];
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (cnt_reg < CNT_W'(CONF_RAMP))
                begin
                    conf_next = ramp_scaled[RAMP_SHIFT +: CONF_W];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            start_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_DECIDE)
            begin
                active_reg <= active_next;
                start_reg  <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        time_reg   <= time_next;
        rd_idx_reg <= rd_idx_next;
        acc_reg    <= acc_next;
        avg_reg    <= avg_next;
        rep_reg    <= rep_next;
        mag_reg    <= mag_next;
        conf_reg   <= conf_next;
        if (out_load)
        begin
            det_out_reg  <= active_reg;
            drop_out_reg <= rep_reg;
            avg_out_reg  <= avg_reg;
            conf_out_reg <= conf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign detected      = det_out_reg;
    assign reported_drop = drop_out_reg;
    assign average       = avg_out_reg;
    assign confidence    = conf_out_reg;

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (confidence <= CONF_MAX))
        else $error("confidence above full scale");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("held sample count beyond history depth");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV_AVG || state_reg == S_DIV_CONF))
        else $error("divider finished outside a wait state");

    a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_WRITE))
        else $error("accepted transaction did not start the ring write");

endmodule

### sv/mdh_ring.sv
// Sample history memory: one write port, one registered read port.
module mdh_ring
    import mdh_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned POS_W = 3
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [POS_W-1:0]    wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [POS_W-1:0]    rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/mdh_div.sv
// Shared restoring divider, one quotient bit per cycle.
module mdh_div
    import mdh_pkg::*;
#(
    parameter int unsigned N_W = 19,
    parameter int unsigned D_W = 12
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output div_stat_t      stat,
    output logic [N_W-1:0] quotient
);

    localparam int unsigned STEP_W = $clog2(N_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [N_W-1:0]    quo_reg, quo_next;
    logic [D_W-1:0]    dvs_reg, dvs_next;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(N_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next  = {quo_reg[N_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
